FILE: src/tfn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

  localparam int CoordW  = 16;
  localparam int NormW   = 16;
  localparam int MagW    = 31;
  localparam int SumW    = 64;
  localparam int RootW   = 32;
  localparam int QuotW   = 15;
  localparam int UnitOne = 16384;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } face_t;

  typedef struct packed {
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
  } normal_t;

endpackage
`default_nettype wire

FILE: src/tfn_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module tfn_sqrt #(
  parameter int SIDE_W = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_vld,
  input  wire logic [tfn_pkg::SumW-1:0]   s,
  input  wire logic [SIDE_W-1:0]          side_in,
  output logic                            out_vld,
  output logic [tfn_pkg::RootW-1:0]       root,
  output logic [SIDE_W-1:0]               side_out
);
  localparam int N = tfn_pkg::RootW;
  localparam int W = tfn_pkg::SumW;

  logic [W-1:0]      rem  [0:N];
  logic [N-1:0]      rt   [0:N];
  logic [SIDE_W-1:0] side [0:N];
  logic [N:0]        vld;

  assign rem[0]  = s;
  assign rt[0]   = '0;
  assign side[0] = side_in;
  assign vld[0]  = in_vld;

  // one root bit per stage, most significant first
  for (genvar j = 0; j < N; j++) begin : g_st
    localparam int K = N - 1 - j;
    logic [W+1:0] t;
    assign t = ({{(W+2-N){1'b0}}, rt[j]} << (K + 1)) | ((W+2)'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[j+1] <= side[j];
        if ({2'b00, rem[j]} >= t) begin
          rem[j+1] <= rem[j] - t[W-1:0];
          rt[j+1]  <= rt[j] | (N'(1) << K);
        end else begin
          rem[j+1] <= rem[j];
          rt[j+1]  <= rt[j];
        end
      end
    end
  end

  assign out_vld  = vld[N];
  assign root     = rt[N];
  assign side_out = side[N];
endmodule
`default_nettype wire

FILE: src/tfn_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tfn_div #(
  parameter int SIDE_W = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_vld,
  input  wire logic [tfn_pkg::RootW-1:0]  len,
  input  wire logic [tfn_pkg::MagW-1:0]   m [3],
  input  wire logic [SIDE_W-1:0]          side_in,
  output logic                            out_vld,
  output logic [tfn_pkg::QuotW-1:0]       q [3],
  output logic [SIDE_W-1:0]               side_out
);
  localparam int N  = tfn_pkg::QuotW;
  localparam int F  = tfn_pkg::QuotW - 1;
  localparam int RW = tfn_pkg::RootW + N;

  logic [RW-1:0]                rem  [0:N][3];
  logic [N-1:0]                 qq   [0:N][3];
  logic [tfn_pkg::RootW-1:0]    ln   [0:N];
  logic [SIDE_W-1:0]            side [0:N];
  logic [N:0]                   vld;

  // numerator m * 2^14 plus half the divisor, rounding half up
  for (genvar c = 0; c < 3; c++) begin : g_init
    assign rem[0][c] = ({{(RW-tfn_pkg::MagW){1'b0}}, m[c]} << F)
                     + {{(RW-tfn_pkg::RootW+1){1'b0}}, len[tfn_pkg::RootW-1:1]};
    assign qq[0][c]  = '0;
  end
  assign ln[0]   = len;
  assign side[0] = side_in;
  assign vld[0]  = in_vld;

  for (genvar j = 0; j < N; j++) begin : g_st
    localparam int K = N - 1 - j;
    logic [RW-1:0] d;
    assign d = {{N{1'b0}}, ln[j]} << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ln[j+1]   <= ln[j];
        side[j+1] <= side[j];
        for (int c = 0; c < 3; c++) begin
          if (rem[j][c] >= d) begin
            rem[j+1][c] <= rem[j][c] - d;
            qq[j+1][c]  <= qq[j][c] | (N'(1) << K);
          end else begin
            rem[j+1][c] <= rem[j][c];
            qq[j+1][c]  <= qq[j][c];
          end
        end
      end
    end
  end

  assign out_vld  = vld[N];
  assign q        = qq[N];
  assign side_out = side[N];
endmodule
`default_nettype wire

FILE: src/triangle_face_normal.sv
`timescale 1ns / 1ps
`default_nettype none
// triangle_face_normal: unit face normal of one triangle per request. Corners a, b, c come in
// as signed Q3.12; the block forms v1 = a-b and v2 = a-c, their exact cross product, and
// divides it by its length to give signed Q1.14 components (rounded half away from zero,
// magnitude at most 16384). A zero cross product gives a zero normal with degenerate set.
// The pipeline accepts one request every clock unless stalled; each result passes through
// 9 stages of edge, multiply, normalize and square-sum work, 32 stages of the
// bit-per-stage square root and 15 stages of the bit-per-stage divider, plus the output
// register. A stall on the result side freezes the whole pipe and is passed back to the
// input side in the same cycle, so nothing is lost or repeated.
module triangle_face_normal (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            face_valid,
  output logic                 face_stall,
  input  wire tfn_pkg::face_t  face,
  output logic                 normal_valid,
  input  wire logic            normal_stall,
  output tfn_pkg::normal_t     normal
);
  localparam int MW     = tfn_pkg::MagW;
  localparam int SIDE_S = 3 + 1 + 3 * MW;
  localparam int SIDE_D = 4;

  // whole pipe moves together unless a finished result is held back
  logic adv;
  assign adv        = !(normal_valid && normal_stall);
  assign face_stall = !adv;

  logic [9:1] v;

  // stage 1: edges
  logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
  // stage 2: cross partial products
  logic signed [33:0] p [6];
  // stage 3: cross product
  logic signed [34:0] n3 [3];
  // stage 4..6: magnitudes, signs, largest, top bit position
  logic [34:0] mag4 [3], mag5 [3], mag6 [3];
  logic [2:0]  sg4, sg5, sg6, sg7, sg8, sg9;
  logic [34:0] big5;
  logic [5:0]  pos6;
  logic        dg6, dg7, dg8, dg9;
  // stage 7..9: normalized magnitudes, squares, sum
  logic [MW-1:0]     m7 [3], m8 [3], m9 [3];
  logic [2*MW-1:0]   sq8 [3];
  logic [tfn_pkg::SumW-1:0] sum9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[8:1], face_valid};
    end
  end

  logic [5:0] pos_c;
  logic [34:0] sh_c [3];

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < 35; i++) begin
      if (big5[i]) pos_c = 6'(i);
    end
    for (int c = 0; c < 3; c++) begin
      if (pos6 < 6'd30) sh_c[c] = mag6[c] << (6'd30 - pos6);
      else              sh_c[c] = mag6[c] >> (pos6 - 6'd30);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1x <= 17'(face.a_x) - 17'(face.b_x);
      e1y <= 17'(face.a_y) - 17'(face.b_y);
      e1z <= 17'(face.a_z) - 17'(face.b_z);
      e2x <= 17'(face.a_x) - 17'(face.c_x);
      e2y <= 17'(face.a_y) - 17'(face.c_y);
      e2z <= 17'(face.a_z) - 17'(face.c_z);

      p[0] <= e1y * e2z;
      p[1] <= e1z * e2y;
      p[2] <= e1z * e2x;
      p[3] <= e1x * e2z;
      p[4] <= e1x * e2y;
      p[5] <= e1y * e2x;

      n3[0] <= 35'(p[0]) - 35'(p[1]);
      n3[1] <= 35'(p[2]) - 35'(p[3]);
      n3[2] <= 35'(p[4]) - 35'(p[5]);

      for (int c = 0; c < 3; c++) begin
        sg4[c]  <= n3[c][34];
        mag4[c] <= n3[c][34] ? 35'(-n3[c]) : 35'(n3[c]);
      end

      mag5 <= mag4;
      sg5  <= sg4;
      if (mag4[0] >= mag4[1] && mag4[0] >= mag4[2]) big5 <= mag4[0];
      else if (mag4[1] >= mag4[2])                   big5 <= mag4[1];
      else                                           big5 <= mag4[2];

      mag6 <= mag5;
      sg6  <= sg5;
      pos6 <= pos_c;
      dg6  <= (big5 == '0);

      for (int c = 0; c < 3; c++) m7[c] <= sh_c[c][MW-1:0];
      sg7 <= sg6;
      dg7 <= dg6;

      for (int c = 0; c < 3; c++) sq8[c] <= m7[c] * m7[c];
      m8  <= m7;
      sg8 <= sg7;
      dg8 <= dg7;

      sum9 <= {2'b00, sq8[0]} + {2'b00, sq8[1]} + {2'b00, sq8[2]};
      m9   <= m8;
      sg9  <= sg8;
      dg9  <= dg8;
    end
  end

  // square root of the sum of squares
  logic                     sq_vld;
  logic [tfn_pkg::RootW-1:0] len;
  logic [SIDE_S-1:0]        sq_side;

  tfn_sqrt #(.SIDE_W(SIDE_S)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (v[9]),
    .s        (sum9),
    .side_in  ({sg9, dg9, m9[2], m9[1], m9[0]}),
    .out_vld  (sq_vld),
    .root     (len),
    .side_out (sq_side)
  );

  logic [MW-1:0] md [3];
  assign md[0] = sq_side[MW-1:0];
  assign md[1] = sq_side[2*MW-1:MW];
  assign md[2] = sq_side[3*MW-1:2*MW];

  // rounded quotient of each magnitude over the length
  logic                        dv_vld;
  logic [tfn_pkg::QuotW-1:0]   q [3];
  logic [SIDE_D-1:0]           dv_side;

  tfn_div #(.SIDE_W(SIDE_D)) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (sq_vld),
    .len      (len),
    .m        (md),
    .side_in  (sq_side[SIDE_S-1:3*MW]),
    .out_vld  (dv_vld),
    .q        (q),
    .side_out (dv_side)
  );

  // clamp, apply sign, force zero on a degenerate face
  logic signed [tfn_pkg::NormW-1:0] comp [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [tfn_pkg::NormW-1:0] mg;
      mg = (q[c] > tfn_pkg::QuotW'(tfn_pkg::UnitOne)) ? tfn_pkg::NormW'(tfn_pkg::UnitOne)
                                                      : tfn_pkg::NormW'(q[c]);
      if (dv_side[0])            comp[c] = '0;
      else if (dv_side[1 + c])   comp[c] = -mg;
      else                       comp[c] = mg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (adv) begin
      normal_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal.normal_x   <= comp[0];
      normal.normal_y   <= comp[1];
      normal.normal_z   <= comp[2];
      normal.degenerate <= dv_side[0];
    end
  end
endmodule
`default_nettype wire

FILE: src/tfn_check.sv
`timescale 1ns / 1ps
`default_nettype none
module tfn_check (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             face_valid,
  input wire logic             face_stall,
  input wire tfn_pkg::face_t   face,
  input wire logic             normal_valid,
  input wire logic             normal_stall,
  input wire tfn_pkg::normal_t normal
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    normal_valid && normal_stall |=> normal_valid && $stable(normal))
    else $error("result changed while stalled");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    face_stall |-> normal_valid && normal_stall)
    else $error("input stalled without output backpressure");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    normal_valid && normal.degenerate |->
      normal.normal_x == 16'sd0 && normal.normal_y == 16'sd0 && normal.normal_z == 16'sd0)
    else $error("degenerate face with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    normal_valid |->
      normal.normal_x <= 16'sd16384 && normal.normal_x >= -16'sd16384 &&
      normal.normal_y <= 16'sd16384 && normal.normal_y >= -16'sd16384 &&
      normal.normal_z <= 16'sd16384 && normal.normal_z >= -16'sd16384)
    else $error("normal component out of range");
endmodule

bind triangle_face_normal tfn_check u_tfn_check (.*);
`default_nettype wire
